/* src/cpb_pkg.sv */
package cpb_pkg;

  typedef logic [1:0] opcode_t;
  typedef logic [2:0] depth_t;
  typedef logic [2:0] reg_index_t;

  localparam opcode_t OP_IMAGE   = 2'd0;
  localparam opcode_t OP_PALETTE = 2'd1;
  localparam opcode_t OP_DRAW    = 2'd2;

  localparam depth_t MODE_1BPP  = 3'd0;
  localparam depth_t MODE_4BPP  = 3'd1;
  localparam depth_t MODE_8BPP  = 3'd2;
  localparam depth_t MODE_24BPP = 3'd3;
  localparam depth_t MODE_32BPP = 3'd4;

  localparam reg_index_t REG_DEPTH_MODE = 3'd0;
  localparam reg_index_t REG_COLOR_KEY  = 3'd1;
  localparam reg_index_t REG_SRC_WIDTH  = 3'd2;
  localparam reg_index_t REG_SRC_HEIGHT = 3'd3;
  localparam reg_index_t REG_DST_WIDTH  = 3'd4;
  localparam reg_index_t REG_DST_HEIGHT = 3'd5;
  localparam reg_index_t REG_ORIGIN_X   = 3'd6;
  localparam reg_index_t REG_ORIGIN_Y   = 3'd7;

  localparam int SIZE_W  = 13;
  localparam int SIZE_MAX = 8191;
  localparam int LANES   = 4;

endpackage

/* src/color_keyed_palette_blit.sv */
// Channel    Handshake                  Payload
// item       item_valid / item_stall    opcode, store_address, store_data, dest_x, dest_y
// result     result_valid / result_stall write_enable, dest_address, pixel_color
// config     APB psel/penable/pready    paddr, pwdata, prdata
//
// One transaction per cycle while the result is not stalled.
// Stages: clip, stride and address multiplies, image byte-lane read, palette read.
// The image store is four byte lanes so an unaligned 24/32bpp pixel reads in one access.
// Reset (rst, synchronous) clears the stage valids and the registers; the stores are not cleared.
// A stalled result holds its stage; earlier stages keep filling bubbles.
module color_keyed_palette_blit #(
  parameter int IMAGE_BYTES     = 16384,
  parameter int PALETTE_ENTRIES = 256,
  parameter int COORD_LIMIT     = 4096
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  cpb_pkg::opcode_t opcode,
  input  logic [13:0]      store_address,
  input  logic [31:0]      store_data,
  input  logic [11:0]      dest_x,
  input  logic [11:0]      dest_y,
  output logic             result_valid,
  input  logic             result_stall,
  output logic             write_enable,
  output logic [23:0]      dest_address,
  output logic [31:0]      pixel_color,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [4:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import cpb_pkg::*;

  localparam int WORDS = (IMAGE_BYTES + LANES - 1) / LANES;
  localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int PIW   = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int CLAMP = (COORD_LIMIT > SIZE_MAX) ? SIZE_MAX : COORD_LIMIT;

  // configuration
  depth_t            depth_mode;
  logic [31:0]       color_key;
  logic [SIZE_W-1:0] src_width, src_height, dst_width, dst_height;
  logic [SIZE_W-1:0] origin_x, origin_y;
  logic              cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_mode <= MODE_8BPP;
      color_key  <= '0;
      src_width  <= 13'd64;
      src_height <= 13'd64;
      dst_width  <= 13'd640;
      dst_height <= 13'd480;
      origin_x   <= '0;
      origin_y   <= '0;
    end else if (cfg_write) begin
      case (paddr[4:2])
        REG_DEPTH_MODE: depth_mode <= pwdata[2:0];
        REG_COLOR_KEY:  color_key  <= pwdata;
        REG_SRC_WIDTH:  src_width  <= pwdata[SIZE_W-1:0];
        REG_SRC_HEIGHT: src_height <= pwdata[SIZE_W-1:0];
        REG_DST_WIDTH:  dst_width  <= pwdata[SIZE_W-1:0];
        REG_DST_HEIGHT: dst_height <= pwdata[SIZE_W-1:0];
        REG_ORIGIN_X:   origin_x   <= pwdata[SIZE_W-1:0];
        REG_ORIGIN_Y:   origin_y   <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_DEPTH_MODE: prdata = {29'd0, depth_mode};
      REG_COLOR_KEY:  prdata = color_key;
      REG_SRC_WIDTH:  prdata = {19'd0, src_width};
      REG_SRC_HEIGHT: prdata = {19'd0, src_height};
      REG_DST_WIDTH:  prdata = {19'd0, dst_width};
      REG_DST_HEIGHT: prdata = {19'd0, dst_height};
      REG_ORIGIN_X:   prdata = {19'd0, origin_x};
      REG_ORIGIN_Y:   prdata = {19'd0, origin_y};
      default:        prdata = '0;
    endcase
  end

  // saturated sizes
  logic [SIZE_W-1:0] sw, sh, dw, dh;
  assign sw = (src_width  > SIZE_W'(CLAMP)) ? SIZE_W'(CLAMP) : src_width;
  assign sh = (src_height > SIZE_W'(CLAMP)) ? SIZE_W'(CLAMP) : src_height;
  assign dw = (dst_width  > SIZE_W'(CLAMP)) ? SIZE_W'(CLAMP) : dst_width;
  assign dh = (dst_height > SIZE_W'(CLAMP)) ? SIZE_W'(CLAMP) : dst_height;

  // stage advance
  logic v1, v2, v3, v4;
  logic ld1, ld2, ld3, ld4;
  assign ld4 = !v4 || !result_stall;
  assign ld3 = !v3 || ld4;
  assign ld2 = !v2 || ld3;
  assign ld1 = !v1 || ld2;
  assign item_stall = !ld1;

  // stage 1: clip
  logic signed [14:0] col_c, row_c;
  logic               clip_c;
  assign col_c = signed'({3'd0, dest_x}) - signed'({{2{origin_x[12]}}, origin_x});
  assign row_c = signed'({3'd0, dest_y}) - signed'({{2{origin_y[12]}}, origin_y});
  assign clip_c = ({1'b0, dest_x} < dw) && ({1'b0, dest_y} < dh)
               && !col_c[14] && (col_c < signed'({2'd0, sw}))
               && !row_c[14] && (row_c < signed'({2'd0, sh}))
               && (depth_mode <= MODE_32BPP);

  opcode_t           op1;
  logic [13:0]       sa1;
  logic [31:0]       sd1;
  logic [11:0]       px1, py1;
  logic [SIZE_W-1:0] col1, row1;
  logic              ok1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ld1) begin
      v1 <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      op1  <= opcode;
      sa1  <= store_address;
      sd1  <= store_data;
      px1  <= dest_x;
      py1  <= dest_y;
      col1 <= col_c[SIZE_W-1:0];
      row1 <= row_c[SIZE_W-1:0];
      ok1  <= clip_c;
    end
  end

  // stage 2: row base and destination address
  logic [15:0]       stride_c;
  logic [SIZE_W-1:0] flip_c;
  logic [28:0]       base_c;
  logic [24:0]       dprod_c;

  always_comb begin
    case (depth_mode)
      MODE_1BPP:  stride_c = (({3'd0, sw} + 16'd31) >> 5) << 2;
      MODE_4BPP:  stride_c = (({3'd0, sw} + 16'd7) >> 3) << 2;
      MODE_8BPP:  stride_c = ({3'd0, sw} + 16'd3) & ~16'd3;
      MODE_24BPP: stride_c = ({3'd0, sw} * 16'd3 + 16'd3) & ~16'd3;
      default:    stride_c = {1'b0, sw, 2'b00};
    endcase
  end

  assign flip_c  = sh - SIZE_W'(1) - row1;
  assign base_c  = 29'(stride_c) * 29'(flip_c);
  assign dprod_c = 25'(py1) * 25'(dw);

  opcode_t           op2;
  logic [13:0]       sa2;
  logic [31:0]       sd2;
  logic [SIZE_W-1:0] col2;
  logic              ok2;
  logic [28:0]       base2;
  logic [23:0]       daddr2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ld2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ld2) begin
      op2    <= op1;
      sa2    <= sa1;
      sd2    <= sd1;
      col2   <= col1;
      ok2    <= ok1;
      base2  <= base_c;
      daddr2 <= 24'(dprod_c + 25'(px1));
    end
  end

  // stage 2 -> 3: image lane access
  logic [14:0]        off_c;
  logic [31:0]        a_c;
  logic [LANES-1:0]   inr_c;
  logic [LANES-1:0]   lane_we;
  logic [WAW-1:0]     lane_raddr [LANES];
  logic [WAW-1:0]     img_waddr;
  logic [7:0]         lane_q [LANES];
  logic               img_load;

  always_comb begin
    case (depth_mode)
      MODE_1BPP:  off_c = 15'(col2 >> 3);
      MODE_4BPP:  off_c = 15'(col2 >> 1);
      MODE_8BPP:  off_c = 15'(col2);
      MODE_24BPP: off_c = 15'(col2) * 15'd3;
      default:    off_c = {col2, 2'b00};
    endcase
  end

  assign a_c       = 32'(base2) + 32'(off_c);
  assign img_load  = v2 && ld3 && (op2 == OP_IMAGE) && (32'(sa2) < 32'(IMAGE_BYTES));
  assign img_waddr = WAW'(32'(sa2) >> 2);

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      inr_c[k]      = (a_c + 32'(k)) < 32'(IMAGE_BYTES);
      lane_raddr[k] = WAW'((a_c >> 2) + ((32'(k) < 32'(a_c[1:0])) ? 32'd1 : 32'd0));
      lane_we[k]    = img_load && (sa2[1:0] == 2'(k));
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    cpb_ram #(
      .WIDTH(8),
      .DEPTH(WORDS)
    ) u_lane (
      .clk  (clk),
      .we   (lane_we[g]),
      .waddr(img_waddr),
      .wdata(sd2[7:0]),
      .re   (ld3),
      .raddr(lane_raddr[g]),
      .rdata(lane_q[g])
    );
  end

  opcode_t          op3;
  logic [13:0]      sa3;
  logic [31:0]      sd3;
  logic             ok3;
  logic [23:0]      daddr3;
  logic [2:0]       col3;
  logic [1:0]       sh3;
  logic [LANES-1:0] inr3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (ld3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (ld3) begin
      op3    <= op2;
      sa3    <= sa2;
      sd3    <= sd2;
      ok3    <= ok2;
      daddr3 <= daddr2;
      col3   <= col2[2:0];
      sh3    <= a_c[1:0];
      inr3   <= inr_c;
    end
  end

  // stage 3: extract, key test, palette access
  logic [7:0]  byte_c [LANES];
  logic [31:0] kv_c;
  logic        paletted_c, we_c, pal_ok_c, pal_we, pal_re;
  logic [31:0] pal_q;

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      byte_c[k] = lane_q[2'(sh3 + 2'(k))] & {8{inr3[k]}};
    end
    case (depth_mode)
      MODE_1BPP:  kv_c = {31'd0, byte_c[0][3'd7 - col3]};
      MODE_4BPP:  kv_c = {28'd0, col3[0] ? byte_c[0][3:0] : byte_c[0][7:4]};
      MODE_8BPP:  kv_c = {24'd0, byte_c[0]};
      MODE_24BPP: kv_c = {8'd0, byte_c[2], byte_c[1], byte_c[0]};
      default:    kv_c = {byte_c[3], byte_c[2], byte_c[1], byte_c[0]};
    endcase
  end

  assign paletted_c = depth_mode <= MODE_8BPP;
  assign we_c       = (op3 == OP_DRAW) && ok3 && (kv_c != color_key);
  assign pal_ok_c   = kv_c < 32'(PALETTE_ENTRIES);
  assign pal_re     = ld4;
  assign pal_we     = v3 && ld4 && (op3 == OP_PALETTE) && (32'(sa3) < 32'(PALETTE_ENTRIES));

  cpb_ram #(
    .WIDTH(32),
    .DEPTH(PALETTE_ENTRIES)
  ) u_palette (
    .clk  (clk),
    .we   (pal_we),
    .waddr(sa3[PIW-1:0]),
    .wdata(sd3),
    .re   (pal_re),
    .raddr(kv_c[PIW-1:0]),
    .rdata(pal_q)
  );

  logic        we4, direct4, palsel4;
  logic [23:0] daddr4;
  logic [31:0] kv4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4  <= 1'b0;
      we4 <= 1'b0;
    end else if (ld4) begin
      v4  <= v3;
      we4 <= v3 && we_c;
    end
  end

  always_ff @(posedge clk) begin
    if (ld4) begin
      direct4 <= !paletted_c;
      palsel4 <= paletted_c && pal_ok_c;
      daddr4  <= daddr3;
      kv4     <= kv_c;
    end
  end

  assign result_valid = v4;
  assign write_enable = we4;
  assign dest_address = we4 ? daddr4 : '0;
  assign pixel_color  = !we4 ? '0 : direct4 ? kv4 : palsel4 ? pal_q : '0;

  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !v1 |-> !item_stall)
    else $error("input stalled with an empty first stage");

  a_palette_held: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |-> !pal_re)
    else $error("palette read during a stalled result");

  a_write_needs_valid: assert property (@(posedge clk) disable iff (rst)
    write_enable |-> result_valid)
    else $error("write enable without a result");

endmodule

/* src/cpb_ram.sv */
module cpb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* tb/sv/tb_color_keyed_palette_blit.sv */
`timescale 1ns / 1ps

module tb_color_keyed_palette_blit;
  import cpb_pkg::*;

  localparam opcode_t OP_NONE = 2'd3;
  localparam int IMG_BYTES = 16384;
  localparam int FILL_BYTES = 512;
  localparam int PAL_SIZE = 256;
  localparam int SIZE_CAP = 4096;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic        we;
    logic [23:0] addr;
    logic [31:0] colour;
  } pixel_t;

  class pixel_predictor;
    logic [7:0]  image[IMG_BYTES];
    logic [31:0] palette[PAL_SIZE];
    logic [31:0] regs[8];
    pixel_t      pending_pixels[$];
    int          mismatches;
    int          items_seen;
    int          pixels_checked;
    int          pixels_written;

    function new();
      foreach (image[i]) image[i] = 8'd0;
      foreach (palette[i]) palette[i] = 32'd0;
      regs[REG_DEPTH_MODE] = MODE_8BPP;
      regs[REG_COLOR_KEY] = 0;
      regs[REG_SRC_WIDTH] = 64;
      regs[REG_SRC_HEIGHT] = 64;
      regs[REG_DST_WIDTH] = 640;
      regs[REG_DST_HEIGHT] = 480;
      regs[REG_ORIGIN_X] = 0;
      regs[REG_ORIGIN_Y] = 0;
    endfunction

    function void write_reg(reg_index_t idx, logic [31:0] v);
      if (idx == REG_DEPTH_MODE) regs[idx] = v & 32'h7;
      else if (idx == REG_COLOR_KEY) regs[idx] = v;
      else regs[idx] = v & 32'h1fff;
    endfunction

    function longint clamp(reg_index_t idx);
      return (regs[idx] > SIZE_CAP) ? SIZE_CAP : longint'(regs[idx]);
    endfunction

    function longint origin(reg_index_t idx);
      return longint'($signed(regs[idx][12:0]));
    endfunction

    function logic [31:0] rd(longint a);
      return (a >= IMG_BYTES) ? 32'd0 : {24'd0, image[a]};
    endfunction

    // bit 32 set when the depth is a known one
    function logic [32:0] source_value(longint col, longint row);
      longint sw, sh, stride, base, a;
      logic [31:0] v;
      sw = clamp(REG_SRC_WIDTH);
      sh = clamp(REG_SRC_HEIGHT);
      case (regs[REG_DEPTH_MODE][2:0])
        MODE_1BPP:  stride = ((sw + 31) / 32) * 4;
        MODE_4BPP:  stride = ((sw * 4 + 31) / 32) * 4;
        MODE_8BPP:  stride = ((sw + 3) / 4) * 4;
        MODE_24BPP: stride = ((sw * 3 + 3) / 4) * 4;
        MODE_32BPP: stride = sw * 4;
        default: return 33'd0;
      endcase
      base = stride * (sh - 1 - row);
      case (regs[REG_DEPTH_MODE][2:0])
        MODE_1BPP: v = (rd(base + col / 8) >> (7 - (col % 8))) & 32'h1;
        MODE_4BPP: v = (col % 2) ? (rd(base + col / 2) & 32'hf) : (rd(base + col / 2) >> 4);
        MODE_8BPP: v = rd(base + col);
        MODE_24BPP: begin
          a = base + col * 3;
          v = rd(a) | (rd(a + 1) << 8) | (rd(a + 2) << 16);
        end
        default: begin
          a = base + col * 4;
          v = rd(a) | (rd(a + 1) << 8) | (rd(a + 2) << 16) | (rd(a + 3) << 24);
        end
      endcase
      return {1'b1, v};
    endfunction

    function void note_item(opcode_t op, logic [13:0] a, logic [31:0] d,
                            logic [11:0] x, logic [11:0] y);
      pixel_t p;
      longint px, py, col, row, dw;
      logic [32:0] sv;
      p = '0;
      items_seen++;
      case (op)
        OP_IMAGE: if (a < IMG_BYTES) image[a] = d[7:0];
        OP_PALETTE: if (a < PAL_SIZE) palette[a] = d;
        OP_DRAW: begin
          px = x;
          py = y;
          dw = clamp(REG_DST_WIDTH);
          col = px - origin(REG_ORIGIN_X);
          row = py - origin(REG_ORIGIN_Y);
          if (px < dw && py < clamp(REG_DST_HEIGHT) && col >= 0 && col < clamp(REG_SRC_WIDTH)
              && row >= 0 && row < clamp(REG_SRC_HEIGHT)) begin
            sv = source_value(col, row);
            if (sv[32] && sv[31:0] != regs[REG_COLOR_KEY]) begin
              p.we = 1'b1;
              p.addr = 24'(py * dw + px);
              p.colour = (regs[REG_DEPTH_MODE] <= MODE_8BPP) ?
                         ((sv[31:0] < PAL_SIZE) ? palette[sv[7:0]] : 32'd0) : sv[31:0];
            end
          end
        end
        default: ;
      endcase
      pending_pixels.push_back(p);
    endfunction

    function void check_pixel(logic we, logic [23:0] a, logic [31:0] c);
      pixel_t e;
      pixel_t got;
      got = {we, a, c};
      pixels_checked++;
      if (we) pixels_written++;
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: we=%0b addr=%h colour=%h", we, a, c);
        return;
      end
      e = pending_pixels.pop_front();
      if (got !== e) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp we=%0b addr=%h colour=%h, got we=%0b addr=%h colour=%h",
                   e.we, e.addr, e.colour, we, a, c);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  opcode_t     opcode = OP_IMAGE;
  logic [13:0] store_address = '0;
  logic [31:0] store_data = '0;
  logic [11:0] dest_x = '0;
  logic [11:0] dest_y = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic        write_enable;
  logic [23:0] dest_address;
  logic [31:0] pixel_color;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  pixel_predictor pred = new();
  int send_pct = 0;
  int recv_pct = 0;
  int cycles = 0;

  color_keyed_palette_blit dut (.*);

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout");
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && !item_stall)
        pred.note_item(opcode, store_address, store_data, dest_x, dest_y);
      if (result_valid && !result_stall)
        pred.check_pixel(write_enable, dest_address, pixel_color);
    end
  end

  always @(negedge clk) result_stall = (recv_pct > 0) && ($urandom_range(0, 99) < recv_pct);

  task automatic send_item(opcode_t op, logic [13:0] a, logic [31:0] d,
                           logic [11:0] x, logic [11:0] y);
    while (send_pct > 0 && $urandom_range(0, 99) < send_pct) begin
      item_valid = 1'b0;
      @(negedge clk);
    end
    item_valid = 1'b1;
    opcode = op;
    store_address = a;
    store_data = d;
    dest_x = x;
    dest_y = y;
    do @(posedge clk); while (item_stall);
    @(negedge clk);
  endtask

  task automatic draw(longint x, longint y);
    send_item(OP_DRAW, 14'($urandom), $urandom, 12'(x), 12'(y));
  endtask

  task automatic drain();
    item_valid = 1'b0;
    while (pred.pending_pixels.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic reg_write(reg_index_t idx, logic [31:0] v);
    pred.write_reg(idx, v);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = 5'(idx * 4);
    pwdata = v;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic configure(depth_t m, logic [31:0] key, int sw, int sh, int dw, int dh,
                           int ox, int oy);
    drain();
    reg_write(REG_DEPTH_MODE, 32'(m));
    reg_write(REG_SRC_WIDTH, sw);
    reg_write(REG_SRC_HEIGHT, sh);
    reg_write(REG_DST_WIDTH, dw);
    reg_write(REG_DST_HEIGHT, dh);
    reg_write(REG_ORIGIN_X, 32'(ox) & 32'h1fff);
    reg_write(REG_ORIGIN_Y, 32'(oy) & 32'h1fff);
    reg_write(REG_COLOR_KEY, key);
  endtask

  // key taken from a live source pixel so that suppression is exercised
  task automatic key_from_pixel();
    logic [32:0] sv;
    sv = pred.source_value(longint'($urandom_range(0, 3)) % pred.clamp(REG_SRC_WIDTH),
                           longint'($urandom_range(0, 3)) % pred.clamp(REG_SRC_HEIGHT));
    reg_write(REG_COLOR_KEY, sv[31:0]);
  endtask

  task automatic phase_corners();
    longint ox, oy, sw, sh;
    ox = pred.origin(REG_ORIGIN_X);
    oy = pred.origin(REG_ORIGIN_Y);
    sw = pred.clamp(REG_SRC_WIDTH);
    sh = pred.clamp(REG_SRC_HEIGHT);
    if (ox >= 0 && oy >= 0) draw(ox, oy);
    if (ox + sw - 1 >= 0 && ox + sw - 1 < 4096 && oy + sh - 1 >= 0 && oy + sh - 1 < 4096)
      draw(ox + sw - 1, oy + sh - 1);
    draw(pred.clamp(REG_DST_WIDTH) - 1, pred.clamp(REG_DST_HEIGHT) - 1);
    draw(4095, 4095);
    draw(0, 0);
  endtask

  task automatic random_item();
    int r;
    longint x, y;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      send_item(OP_IMAGE, 14'($urandom), $urandom, 12'($urandom), 12'($urandom));
    end else if (r < 18) begin
      send_item(OP_PALETTE, 14'($urandom_range(0, 511)), $urandom, 12'($urandom),
                12'($urandom));
    end else if (r < 21) begin
      send_item(OP_NONE, 14'($urandom), $urandom, 12'($urandom), 12'($urandom));
    end else if (r < 37) begin
      draw($urandom_range(0, 4095), $urandom_range(0, 4095));
    end else begin
      x = pred.origin(REG_ORIGIN_X) + $urandom_range(0, pred.clamp(REG_SRC_WIDTH) - 1);
      y = pred.origin(REG_ORIGIN_Y) + $urandom_range(0, pred.clamp(REG_SRC_HEIGHT) - 1);
      if (x < 0 || x > 4095) x = $urandom_range(0, 4095);
      if (y < 0 || y > 4095) y = $urandom_range(0, 4095);
      draw(x, y);
    end
  endtask

  task automatic run_random(int n, int mode);
    send_pct = (mode == 1) ? 81 : (mode == 3) ? 38 : 0;
    recv_pct = (mode == 2) ? 81 : (mode == 3) ? 38 : 0;
    phase_corners();
    repeat (n) random_item();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // low image bytes and the whole palette; most source footprints below fit there, but the 30x30
    // 32bpp one needs more and the large one reads past the store end except on its bottom row
    for (int i = 0; i < FILL_BYTES; i++) send_item(OP_IMAGE, 14'(i), $urandom, 12'd0, 12'd0);
    for (int i = 0; i < PAL_SIZE; i++) send_item(OP_PALETTE, 14'(i), $urandom, 12'd0, 12'd0);
    send_item(OP_PALETTE, 14'h3fff, 32'hffffffff, 12'hfff, 12'hfff);
    send_item(OP_IMAGE, 14'h3fff, 32'hffffffff, 12'hfff, 12'hfff);
    send_item(OP_PALETTE, 14'd0, 32'h0, 12'd0, 12'd0);
    send_item(OP_NONE, 14'h3fff, 32'hffffffff, 12'hfff, 12'hfff);
    send_item(OP_NONE, 14'd0, 32'd0, 12'd0, 12'd0);

    configure(MODE_8BPP, 0, 32, 16, 640, 480, 0, 0);
    run_random(120, 0);
    configure(MODE_1BPP, 1, 1, 1, 1, 1, 0, 0);
    run_random(90, 1);
    configure(MODE_1BPP, 0, 77, 33, 300, 200, 5, 9);
    run_random(115, 2);
    configure(MODE_4BPP, 5, 100, 9, 4096, 4096, 4095, 4095);
    run_random(60, 3);
    drain();
    run_random(60, 0);
    configure(MODE_24BPP, 0, 37, 4, 8191, 300, -20, -1);
    key_from_pixel();
    run_random(130, 1);
    configure(MODE_32BPP, 0, 30, 30, 200, 8191, -4096, -4096);
    run_random(60, 2);
    configure(MODE_32BPP, 0, 21, 6, 100, 90, 40, 30);
    key_from_pixel();
    run_random(115, 3);
    configure(MODE_32BPP, 32'hffffffff, 4096, 8191, 138, 4096, 10, 0);
    run_random(90, 0);
    configure(depth_t'(5), 0, 20, 20, 64, 64, 0, 0);
    run_random(45, 1);
    configure(depth_t'(7), 0, 20, 20, 64, 64, 0, 0);
    run_random(45, 2);
    configure(MODE_8BPP, 0, 13, 7, 50, 50, 3, 2);
    key_from_pixel();
    run_random(145, 3);

    drain();
    send_pct = 0;
    recv_pct = 0;
    repeat (20) @(negedge clk);
    $display("covered %0d transactions in, %0d results (%0d pixel writes)",
             pred.items_seen, pred.pixels_checked, pred.pixels_written);
    $display("depths 1/4/8/24/32bpp plus unknown, clipping, keying and size saturation");
    if (pred.mismatches == 0 && pred.pending_pixels.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches, %0d results missing", pred.mismatches,
               pred.pending_pixels.size());
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* files.f */
src/cpb_pkg.sv
src/cpb_ram.sv
src/color_keyed_palette_blit.sv
tb/sv/tb_color_keyed_palette_blit.sv
